[rtl/core/acmac_pkg.sv]
package acmac_pkg;

  typedef struct packed {
    logic [127:0] data;
    logic [4:0]   byte_count;
    logic         final_block;
  } blk_t;

  localparam logic CFG_KEY_HI = 1'b0;
  localparam logic CFG_KEY_LO = 1'b1;

  localparam logic [7:0] RB_CONST  = 8'h87;
  localparam logic [7:0] PAD_CONST = 8'h80;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] round(input logic [127:0] s, input logic [127:0] rk,
                                         input logic last);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127-8*(i+4*c) -: 8] = sbox(byte_of(s, i + 4*((c+i)%4)));
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = byte_of(t, 4*c); a1 = byte_of(t, 4*c+1);
        a2 = byte_of(t, 4*c+2); a3 = byte_of(t, 4*c+3);
        x = a0 ^ a1 ^ a2 ^ a3;
        t[127-32*c -: 32] = {a0 ^ x ^ xt(a0 ^ a1), a1 ^ x ^ xt(a1 ^ a2),
                             a2 ^ x ^ xt(a2 ^ a3), a3 ^ x ^ xt(a3 ^ a0)};
      end
    end
    return t ^ rk;
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, v[127] ? RB_CONST : 8'h00};
  endfunction

endpackage

[rtl/core/acmac_front.sv]
module acmac_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  acmac_pkg::blk_t    in_blk,
  output logic               q_valid,
  input  logic               q_stall,
  output acmac_pkg::blk_t    q_blk
);
  acmac_pkg::blk_t mem [2];
  logic [1:0] wp, rp;

  assign in_stall = (wp[1] != rp[1]) && (wp[0] == rp[0]);
  assign q_valid  = wp != rp;
  assign q_blk    = mem[rp[0]];

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mem[wp[0]] <= in_blk;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (in_valid && !in_stall) wp <= wp + 2'd1;
      if (q_valid && !q_stall) rp <= rp + 2'd1;
    end
  end
endmodule

[rtl/core/acmac_back.sv]
module acmac_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [127:0]       key,
  input  logic               q_valid,
  output logic               q_stall,
  input  acmac_pkg::blk_t    q_blk,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [127:0]       mac
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SUBK = 3'b010,
    S_ENC  = 3'b100
  } state_t;

  state_t state, state_next;
  logic [127:0] st, rk, chain, k1, k2;
  logic [3:0]   rnd;
  logic [7:0]   rc;
  logic         started, last;
  logic [4:0]   cnt;
  logic [127:0] msg, pad, st_r, rk_n;
  logic         done;

  assign rk_n = acmac_pkg::next_rk(rk, rc);
  assign st_r = acmac_pkg::round(st, rk_n, rnd == 4'd10);
  assign done = rnd == 4'd10;
  assign q_stall = (state != S_IDLE) || !started || (out_valid && q_blk.final_block);

  always_comb begin
    cnt = (q_blk.byte_count > 5'd16) ? 5'd16 : q_blk.byte_count;
    for (int j = 0; j < 16; j++) begin
      if (j < cnt) pad[127-8*j -: 8] = q_blk.data[127-8*j -: 8];
      else if (j == cnt) pad[127-8*j -: 8] = acmac_pkg::PAD_CONST;
      else pad[127-8*j -: 8] = 8'h00;
    end
    if (!q_blk.final_block) msg = q_blk.data;
    else if (cnt == 5'd16) msg = q_blk.data ^ k1;
    else msg = pad ^ k2;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid && !q_stall) state_next = S_ENC;
        else if (q_valid && !started) state_next = S_SUBK;
      end
      S_SUBK: if (done) state_next = S_IDLE;
      S_ENC:  if (done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid && !q_stall) begin
          rk   <= key;
          rnd  <= 4'd1;
          rc   <= 8'h01;
          last <= q_blk.final_block;
          st   <= chain ^ msg ^ key;
        end else if (q_valid && !started) begin
          rk    <= key;
          rnd   <= 4'd1;
          rc    <= 8'h01;
          st    <= key;
          chain <= '0;
        end
      end
      S_SUBK: begin
        st  <= st_r;
        rk  <= rk_n;
        rnd <= rnd + 4'd1;
        rc  <= acmac_pkg::xt(rc);
        if (done) begin
          k1 <= acmac_pkg::dbl(st_r);
          k2 <= acmac_pkg::dbl(acmac_pkg::dbl(st_r));
        end
      end
      default: begin
        st  <= st_r;
        rk  <= rk_n;
        rnd <= rnd + 4'd1;
        rc  <= acmac_pkg::xt(rc);
        if (done) begin
          chain <= st_r;
          if (last) mac <= st_r;
        end
      end
    endcase
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_SUBK && done) started <= 1'b1;
      if (state == S_ENC && done) begin
        if (last) begin
          started   <= 1'b0;
          out_valid <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/core/aes128_cmac_engine_core.sv]
// Subkey derivation runs before the first block of a message; each block is then encrypted.
// Blocks are processed one at a time by the single shared AES round unit (one round/cycle).
// A two-entry queue takes blocks while the round unit works; the MAC register holds the result.
// Reset (rst, synchronous, active high) clears keys, queue, state and output valid.
module aes128_cmac_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_hi,
  input  logic [63:0] data_lo,
  input  logic [4:0]  byte_count,
  input  logic        final_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] mac_hi,
  output logic [63:0] mac_lo
);
  logic [63:0] key_hi, key_lo;
  acmac_pkg::blk_t in_blk, q_blk;
  logic q_valid, q_stall;
  logic [127:0] mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
    end else if (cfg_we) begin
      if (cfg_index == acmac_pkg::CFG_KEY_HI) key_hi <= cfg_data;
      else key_lo <= cfg_data;
    end
  end

  assign in_blk = '{data: {data_hi, data_lo}, byte_count: byte_count, final_block: final_block};

  acmac_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_blk,
    .q_valid, .q_stall, .q_blk
  );

  acmac_back u_back (
    .clk, .rst, .key({key_hi, key_lo}), .q_valid, .q_stall, .q_blk,
    .out_valid, .out_stall, .mac
  );

  assign mac_hi = mac[127:64];
  assign mac_lo = mac[63:0];
endmodule

[rtl/core/acmac_checker.sv]
module acmac_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] mac_hi,
  input logic [63:0] mac_lo
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mac_hi) && $stable(mac_lo))
    else $error("mac beat changed under stall");
  a_rst_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("out_valid after reset");
  a_no_fast: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated too soon");
  a_rst_ready: assert property (@(posedge clk) $past(rst) |-> !in_stall)
    else $error("input stalled after reset");
endmodule

bind aes128_cmac_engine_core acmac_checker u_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .mac_hi, .mac_lo
);

[tb/aes128_cmac_engine_core_test.sv]
`timescale 1ns / 100ps

module aes128_cmac_engine_core_test;

  typedef struct {
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [4:0]  byte_count;
    logic        final_block;
  } block_beat_t;

  typedef struct {
    logic [63:0] mac_hi;
    logic [63:0] mac_lo;
  } mac_beat_t;

  logic clk, rst;
  logic cfg_we, cfg_index;
  logic [63:0] cfg_data;
  logic in_valid, in_stall;
  logic [63:0] data_hi, data_lo;
  logic [4:0] byte_count;
  logic final_block;
  logic out_valid, out_stall;
  logic [63:0] mac_hi, mac_lo;

  aes128_cmac_engine_core dut (.*);

  block_beat_t pending_blocks[$];
  mac_beat_t   expected_macs[$];
  int errors = 0;
  int macs_seen = 0;
  int blocks_sent = 0;
  bit quiet_mode = 0;
  bit hold_sink = 0;

  logic [127:0] key_shadow;
  logic [127:0] chain_shadow, k1_shadow, k2_shadow;
  bit started_shadow;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic logic [7:0] sb(input logic [7:0] a);
    logic [7:0] t[256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] mul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] rk[176];
    logic [7:0] st[16];
    logic [7:0] t[16];
    logic [7:0] w0, w1, w2, w3, tmp, a0, a1, a2, a3, s;
    logic [7:0] rc;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
      if ((i % 16) == 0) begin
        tmp = w0;
        w0 = sb(w1) ^ rc; w1 = sb(w2); w2 = sb(w3); w3 = sb(tmp);
        rc = mul2(rc);
      end
      rk[i] = rk[i-16] ^ w0; rk[i+1] = rk[i-15] ^ w1;
      rk[i+2] = rk[i-14] ^ w2; rk[i+3] = rk[i-13] ^ w3;
    end
    for (int i = 0; i < 16; i++) st[i] = pt[127-8*i -: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = sb(st[i + 4*((c+i) % 4)]);
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          s = a0 ^ a1 ^ a2 ^ a3;
          t[4*c] = a0 ^ s ^ mul2(a0 ^ a1);
          t[4*c+1] = a1 ^ s ^ mul2(a1 ^ a2);
          t[4*c+2] = a2 ^ s ^ mul2(a2 ^ a3);
          t[4*c+3] = a3 ^ s ^ mul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, v[127] ? 8'h87 : 8'h00};
  endfunction

  task automatic absorb_block(input block_beat_t b);
    logic [127:0] blk, pad;
    mac_beat_t m;
    int cnt;
    if (!started_shadow) begin
      k1_shadow = gf_double(aes_encrypt(key_shadow, 128'd0));
      k2_shadow = gf_double(k1_shadow);
      chain_shadow = '0;
      started_shadow = 1;
    end
    blk = {b.data_hi, b.data_lo};
    if (b.final_block) begin
      cnt = (b.byte_count > 16) ? 16 : b.byte_count;
      if (cnt == 16) begin
        blk = blk ^ k1_shadow;
      end else begin
        for (int j = cnt; j < 16; j++) blk[127-8*j -: 8] = (j == cnt) ? 8'h80 : 8'h00;
        blk = blk ^ k2_shadow;
      end
    end
    chain_shadow = aes_encrypt(key_shadow, chain_shadow ^ blk);
    if (b.final_block) begin
      started_shadow = 0;
      m.mac_hi = chain_shadow[127:64];
      m.mac_lo = chain_shadow[63:0];
      expected_macs.push_back(m);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] cnt, input logic fin);
    block_beat_t b;
    b.data_hi = hi; b.data_lo = lo; b.byte_count = cnt; b.final_block = fin;
    pending_blocks.push_back(b);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // driver
  int src_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
    end else begin
      if (in_valid) begin
        absorb_block(pending_blocks.pop_front());
        blocks_sent++;
      end
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_blocks.size() > 0 && !(in_valid && pending_blocks.size() == 0)) begin
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(1, 4) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          data_hi <= pending_blocks[0].data_hi;
          data_lo <= pending_blocks[0].data_lo;
          byte_count <= pending_blocks[0].byte_count;
          final_block <= pending_blocks[0].final_block;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sink stall
  int sink_gap = 0;
  always @(negedge clk) begin
    if (rst || quiet_mode) begin
      out_stall <= 1'b0;
    end else if (hold_sink) begin
      out_stall <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(1, 4) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      macs_seen++;
      if (expected_macs.size() == 0) begin
        report_mismatch("unexpected mac_hi", mac_hi, 64'd0);
      end else begin
        if (mac_hi !== expected_macs[0].mac_hi)
          report_mismatch("mac_hi", mac_hi, expected_macs[0].mac_hi);
        if (mac_lo !== expected_macs[0].mac_lo)
          report_mismatch("mac_lo", mac_lo, expected_macs[0].mac_lo);
        void'(expected_macs.pop_front());
      end
    end
  end

  task automatic drain();
    while (pending_blocks.size() > 0 || in_valid || expected_macs.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_key(input logic [127:0] k);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= acmac_pkg::CFG_KEY_HI; cfg_data <= k[127:64];
    @(negedge clk);
    cfg_index <= acmac_pkg::CFG_KEY_LO; cfg_data <= k[63:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    key_shadow = k;
  endtask

  task automatic queue_message(input int nblk);
    for (int i = 0; i < nblk - 1; i++) queue_block(rand64(), rand64(), 5'($urandom), 1'b0);
    queue_block(rand64(), rand64(), ($urandom_range(0, 3) == 0) ? 5'd16 :
                ($urandom_range(0, 9) == 0 ? 5'($urandom_range(17, 31)) :
                 5'($urandom_range(0, 16))),
                1'b1);
  endtask

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_index = acmac_pkg::CFG_KEY_HI; cfg_data = '0;
    in_valid = 1'b0; out_stall = 1'b0;
    data_hi = '0; data_lo = '0; byte_count = '0; final_block = 1'b0;
    key_shadow = '0; chain_shadow = '0; k1_shadow = '0; k2_shadow = '0;
    started_shadow = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    queue_block('0, '0, 5'd0, 1'b1);
    queue_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
    queue_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd0, 1'b0);
    queue_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd8, 1'b1);
    queue_block('1, '1, 5'd31, 1'b1);
    queue_block('1, '1, 5'd1, 1'b1);
    queue_block('1, '1, 5'd15, 1'b0);
    queue_block('1, '1, 5'd0, 1'b1);
    queue_block('0, '1, 5'd17, 1'b1);
    queue_block('1, '0, 5'd7, 1'b1);
    drain();

    write_key('1);
    queue_block('0, '0, 5'd16, 1'b1);
    queue_block('1, '1, 5'd3, 1'b1);
    drain();

    // mid-message key change: subkeys stay from message start
    queue_block(rand64(), rand64(), 5'd16, 1'b0);
    drain();
    write_key('0);
    queue_block(rand64(), rand64(), 5'd9, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_key({rand64(), rand64()});
      hold_sink = (ph == 1);
      for (int n = 0; n < 250; ) begin
        int len;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
        queue_message(len);
        n += len;
        if (ph == 1 && n > 20 && hold_sink) begin
          repeat (200) @(posedge clk);
          hold_sink = 0;
        end
      end
      if (ph == 5) quiet_mode = 1;
      drain();
    end

    $display("sent %0d message blocks over nine key settings, %0d MACs checked",
             blocks_sent, macs_seen);
    $display("covered empty, partial, full and oversized final blocks with long stalls");
    if (errors == 0) begin
      $display("** aes128_cmac_engine_core: PASSED **");
    end else begin
      $display("** aes128_cmac_engine_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** aes128_cmac_engine_core: FAILED **");
    $finish;
  end

endmodule
